/* design/assert_macros.svh */
// shared assertion macros for the frame checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RFC8_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define RFC8_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define RFC8_ASSERT(lbl, clk, rstn, prop, msg)
`define RFC8_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

/* design/rfc8_pkg.sv */
package rfc8_pkg;

    localparam int MAX_FRAME = 32;
    localparam int FRAME_AW  = $clog2(MAX_FRAME);
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);
    localparam int CMP_W     = (CNT_W > 6) ? CNT_W : 6;

    localparam int BYTE_W    = 8;
    localparam int PLEN_W    = 5;
    localparam int FB_W      = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [PLEN_W-1:0] PAYLOAD_CAP  = 5'd28;
    localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd62;
    localparam logic [BYTE_W-1:0] CRC_POLY_REV = 8'h8C;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANSWER_MARKER  = 1'b0,
        REG_PAYLOAD_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CRC     = 3'd1,
        ST_MARKER  = 3'd2,
        ST_LENGTH  = 3'd3,
        ST_DEVICE  = 3'd4,
        ST_PAYLOAD = 3'd5
    } status_t;

    // dallas/maxim crc-8, lsb first
    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc_in,
                                                    input logic [BYTE_W-1:0] data_in);
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] d;
        crc = crc_in;
        d   = data_in;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (crc[0] ^ d[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY_REV;
            end
            else
            begin
                crc = crc >> 1;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

/* design/response_frame_checker_crc8.sv */
// a byte or timeout word that ends a frame has its result word in the output register
// on the next cycle. a byte that finishes a good frame with payload then gives its
// payload words one by one, each by a ram read (S_FETCH) and an output load (S_EMIT)
// that waits for a free output register; in_ready stays low until the last is loaded.
// one word per cycle while no payload is read out and the output is not stalled;
// reset clears count, crc, output and configuration (marker 62, length 0), not the ram.
module response_frame_checker_crc8 (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [rfc8_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rfc8_pkg::BYTE_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic [rfc8_pkg::BYTE_W-1:0]           data_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rfc8_pkg::status_t                     status,
    output logic [rfc8_pkg::BYTE_W-1:0]           device_status,
    output logic [rfc8_pkg::BYTE_W-1:0]           address,
    output logic [rfc8_pkg::BYTE_W-1:0]           command,
    output logic [rfc8_pkg::FB_W-1:0]             frame_bytes,
    output logic [rfc8_pkg::BYTE_W-1:0]           payload_byte,
    output logic [rfc8_pkg::PLEN_W-1:0]           payload_index,
    output logic                                  last
);

    import rfc8_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } state_t;

    state_t              state_reg,        state_next;
    logic [CNT_W-1:0]    count_reg,        count_next;
    logic [BYTE_W-1:0]   crc_reg,          crc_next;
    logic [BYTE_W-1:0]   byte0_reg,        byte0_next;
    logic [BYTE_W-1:0]   addr_reg,         addr_next;
    logic [BYTE_W-1:0]   cmd_reg,          cmd_next;
    logic [FRAME_AW-1:0] rd_addr_reg,      rd_addr_next;
    logic [PLEN_W-1:0]   idx_reg,          idx_next;
    logic [BYTE_W-1:0]   marker_reg,       marker_next;
    logic [PLEN_W-1:0]   plen_cfg_reg,     plen_cfg_next;

    logic                out_valid_reg,    out_valid_next;
    status_t             out_status_reg,   out_status_next;
    logic [BYTE_W-1:0]   out_dev_reg,      out_dev_next;
    logic [BYTE_W-1:0]   out_addr_reg,     out_addr_next;
    logic [BYTE_W-1:0]   out_cmd_reg,      out_cmd_next;
    logic [FB_W-1:0]     out_nbytes_reg,   out_nbytes_next;
    logic [BYTE_W-1:0]   out_pbyte_reg,    out_pbyte_next;
    logic [PLEN_W-1:0]   out_pidx_reg,     out_pidx_next;
    logic                out_last_reg,     out_last_next;

    logic [PLEN_W-1:0]   plen;
    logic                out_free;
    logic                accept;
    logic [CNT_W-1:0]    n;
    logic [CMP_W-1:0]    n_cmp;
    logic [CMP_W-1:0]    need_cmp;
    logic [BYTE_W-1:0]   crc_new;
    logic                ram_we;
    logic [BYTE_W-1:0]   ram_rdata;

    assign plen     = (plen_cfg_reg > PAYLOAD_CAP) ? PAYLOAD_CAP : plen_cfg_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign n        = count_reg + CNT_W'(1);
    assign n_cmp    = CMP_W'(n);
    assign need_cmp = CMP_W'(plen) + CMP_W'(4);
    assign crc_new  = crc8_step(crc_reg, data_byte);
    assign ram_we   = accept && !operation;

    rfc8_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[FRAME_AW-1:0]),
        .wdata (data_byte),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        crc_next        = crc_reg;
        byte0_next      = byte0_reg;
        addr_next       = addr_reg;
        cmd_next        = cmd_reg;
        rd_addr_next    = rd_addr_reg;
        idx_next        = idx_reg;
        marker_next     = marker_reg;
        plen_cfg_next   = plen_cfg_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_dev_next    = out_dev_reg;
        out_addr_next   = out_addr_reg;
        out_cmd_next    = out_cmd_reg;
        out_nbytes_next = out_nbytes_reg;
        out_pbyte_next  = out_pbyte_reg;
        out_pidx_next   = out_pidx_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ANSWER_MARKER:  marker_next   = cfg_data;
                REG_PAYLOAD_LENGTH: plen_cfg_next = cfg_data[PLEN_W-1:0];
                default:            marker_next   = marker_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation)
                    begin
                        if (count_reg != '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_LENGTH;
                            out_dev_next    = '0;
                            out_addr_next   = '0;
                            out_cmd_next    = '0;
                            out_nbytes_next = FB_W'(count_reg);
                            out_pbyte_next  = '0;
                            out_pidx_next   = '0;
                            out_last_next   = 1'b1;
                            count_next      = '0;
                            crc_next        = '0;
                        end
                    end
                    else
                    begin
                        if (count_reg == CNT_W'(0))
                        begin
                            byte0_next = data_byte;
                        end
                        if (count_reg == CNT_W'(1))
                        begin
                            addr_next = data_byte;
                        end
                        if (count_reg == CNT_W'(2))
                        begin
                            cmd_next = data_byte;
                        end
                        count_next      = n;
                        crc_next        = crc_new;
                        out_dev_next    = '0;
                        out_addr_next   = '0;
                        out_cmd_next    = '0;
                        out_nbytes_next = FB_W'(n);
                        out_pbyte_next  = '0;
                        out_pidx_next   = '0;
                        out_last_next   = 1'b1;
                        if (n == CNT_W'(MAX_FRAME))
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_LENGTH;
                            count_next      = '0;
                            crc_next        = '0;
                        end
                        else if (n_cmp < CMP_W'(4))
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                        else if (byte0_reg != marker_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_MARKER;
                            count_next      = '0;
                            crc_next        = '0;
                        end
                        else if (n_cmp < need_cmp)
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                        else if (crc_reg != data_byte)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_CRC;
                            count_next      = '0;
                            crc_next        = '0;
                        end
                        else
                        begin
                            out_valid_next  = 1'b1;
                            out_addr_next   = addr_reg;
                            out_cmd_next    = cmd_reg;
                            out_last_next   = (plen == '0);
                            count_next      = '0;
                            crc_next        = '0;
                            if (n_cmp == CMP_W'(4))
                            begin
                                out_status_next = ST_DEVICE;
                                out_dev_next    = data_byte;
                            end
                            else
                            begin
                                out_status_next = ST_OK;
                            end
                            if (plen != '0)
                            begin
                                state_next   = S_FETCH;
                                rd_addr_next = FRAME_AW'(3);
                                idx_next     = '0;
                            end
                        end
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_PAYLOAD;
                    out_dev_next    = '0;
                    out_addr_next   = addr_reg;
                    out_cmd_next    = cmd_reg;
                    out_pbyte_next  = ram_rdata;
                    out_pidx_next   = idx_reg;
                    out_last_next   = (PLEN_W'(idx_reg + PLEN_W'(1)) == plen);
                    if (PLEN_W'(idx_reg + PLEN_W'(1)) == plen)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next   = S_FETCH;
                        idx_next     = idx_reg + PLEN_W'(1);
                        rd_addr_next = rd_addr_reg + FRAME_AW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            crc_reg        <= '0;
            byte0_reg      <= '0;
            addr_reg       <= '0;
            cmd_reg        <= '0;
            rd_addr_reg    <= '0;
            idx_reg        <= '0;
            marker_reg     <= MARKER_RESET;
            plen_cfg_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_dev_reg    <= '0;
            out_addr_reg   <= '0;
            out_cmd_reg    <= '0;
            out_nbytes_reg <= '0;
            out_pbyte_reg  <= '0;
            out_pidx_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            crc_reg        <= crc_next;
            byte0_reg      <= byte0_next;
            addr_reg       <= addr_next;
            cmd_reg        <= cmd_next;
            rd_addr_reg    <= rd_addr_next;
            idx_reg        <= idx_next;
            marker_reg     <= marker_next;
            plen_cfg_reg   <= plen_cfg_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_dev_reg    <= out_dev_next;
            out_addr_reg   <= out_addr_next;
            out_cmd_reg    <= out_cmd_next;
            out_nbytes_reg <= out_nbytes_next;
            out_pbyte_reg  <= out_pbyte_next;
            out_pidx_reg   <= out_pidx_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign device_status = out_dev_reg;
    assign address       = out_addr_reg;
    assign command       = out_cmd_reg;
    assign frame_bytes   = out_nbytes_reg;
    assign payload_byte  = out_pbyte_reg;
    assign payload_index = out_pidx_reg;
    assign last          = out_last_reg;

    `RFC8_ASSERT(a_emit_frame_cleared, clk, rst_n, state_reg != S_IDLE |-> count_reg == '0 && crc_reg == '0, "frame state not cleared during payload readout")
    `RFC8_ASSERT(a_emit_index_range, clk, rst_n, state_reg != S_IDLE |-> idx_reg < plen, "payload index beyond payload length")
    `RFC8_ASSERT(a_partial_word_continues, clk, rst_n, out_valid_reg && !out_last_reg |-> state_reg != S_IDLE, "non-final word with no readout in progress")
    `RFC8_ASSERT(a_empty_timeout_silent, clk, rst_n, accept && operation && count_reg == '0 && !out_valid_reg |=> !out_valid_reg, "timeout on empty frame produced a word")
    `RFC8_NEVER(a_count_below_max, clk, rst_n, count_reg >= CNT_W'(MAX_FRAME), "byte count reached frame limit")

endmodule

/* design/rfc8_ram.sv */
module rfc8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
